[design/sda_pkg.sv]
// Package for the scaled decimal to ASCII formatter.
// Holds the sequencer state type, character codes, sizes and the BCD adjust step.
// Has no dependencies.
package sda_pkg;

  localparam int MAG_BITS   = 128;
  localparam int NUM_DIGITS = 39;
  localparam int BCD_BITS   = 4 * NUM_DIGITS;
  localparam int CFG_BITS   = 6;

  localparam logic [CFG_BITS-1:0] MAX_SCALE = 6'd38;
  localparam logic [5:0] TOP_POS = 6'd38;
  localparam logic [6:0] LAST_BIT = 7'd127;

  // Configuration register indexes.
  localparam logic REG_TOTAL_DIGITS    = 1'b0;
  localparam logic REG_FRACTION_DIGITS = 1'b1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_INTEGER,
    ST_POINT,
    ST_FRACTION
  } seq_state_t;

  // Adds three to every BCD digit of five or more, ahead of the next shift.
  function automatic logic [BCD_BITS-1:0] dabble_adjust(input logic [BCD_BITS-1:0] bcd);
    logic [BCD_BITS-1:0] res;
    logic [3:0] d;
    res = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[4*i +: 4];
      if (d >= 4'd5) begin
        res[4*i +: 4] = d + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

[design/scaled_decimal_to_ascii.sv]
// Scaled decimal to ASCII formatter: one signed 128-bit fixed-point value in, its text out.
// Depends on sda_pkg for the state type, character codes and the BCD adjust step.
// Each value passes through double dabble, one magnitude bit per cycle, then a sign step, then
// a walk over all 39 BCD digits, one per cycle, plus the point when the scale is nonzero. Busy
// stays high for the whole of each value, so a new value is taken only once the last one is
// through. Each character is chosen from the current state and registered onto the ports. Reset
// is synchronous: it returns to idle and sets total_digits to 38 and fraction_digits to 0. The
// receiver cannot stall the character stream; the last character shows in the first cycle in
// which busy is low again.
module scaled_decimal_to_ascii (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [63:0]             value_high,
  input  logic        [63:0]             value_low,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [sda_pkg::CFG_BITS-1:0]   cfg_data,
  output logic                           strobe,
  output logic [7:0]                     character,
  output logic                           last
);
  import sda_pkg::*;

  // Configuration registers.
  logic [CFG_BITS-1:0] total_digits;
  logic [CFG_BITS-1:0] fraction_digits;

  // Sequencer state.
  seq_state_t state;
  seq_state_t state_next;

  // Working registers for one value. The magnitude shifts out MSB first into the BCD register,
  // which is then shifted left one digit per cycle so that its top digit is always the one at
  // position pos.
  logic [MAG_BITS-1:0] mag;
  logic [BCD_BITS-1:0] bcd;
  logic [6:0]          bit_cnt;
  logic [5:0]          pos;
  logic                neg;
  logic                seen;
  logic                int_on;
  logic [5:0]          scale;

  logic [MAG_BITS-1:0] value_in;
  logic [BCD_BITS-1:0] bcd_adj;
  logic [3:0]          top;
  logic                top_nz;
  logic [5:0]          scale_in;

  // Output side, computed from the current state and registered onto the ports.
  logic       emit;
  logic [7:0] char_sel;
  logic       last_sel;

  assign value_in = {value_high, value_low};
  assign bcd_adj  = dabble_adjust(bcd);
  assign top      = bcd[BCD_BITS-1 -: 4];
  assign top_nz   = (top != 4'd0);
  assign busy     = (state != ST_IDLE);
  // Scales above 38, the largest one, behave as 38.
  assign scale_in = (fraction_digits > MAX_SCALE) ? MAX_SCALE : fraction_digits;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_digits    <= 6'd38;
      fraction_digits <= 6'd0;
    end else if (cfg_write) begin
      if (cfg_index == REG_TOTAL_DIGITS) begin
        total_digits <= cfg_data;
      end else begin
        fraction_digits <= cfg_data;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (bit_cnt == LAST_BIT) state_next = ST_SIGN;
      end
      ST_SIGN: begin
        state_next = ST_INTEGER;
      end
      ST_INTEGER: begin
        // The integer walk ends on the units digit; a plain integer is then complete.
        if (pos == scale) state_next = (scale == 6'd0) ? ST_IDLE : ST_POINT;
      end
      ST_POINT: begin
        state_next = ST_FRACTION;
      end
      ST_FRACTION: begin
        if (pos == 6'd0) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Character selection for the current state.
  always_comb begin
    emit     = 1'b0;
    char_sel = CHAR_ZERO + {4'd0, top};
    last_sel = 1'b0;
    case (state)
      ST_SIGN: begin
        emit     = neg;
        char_sel = CHAR_MINUS;
      end
      ST_INTEGER: begin
        // Leading zeros are dropped, but the units digit prints whenever the integer part is on, which
        // also yields the lone zero of an all-zero integer part.
        emit     = int_on && (seen || top_nz || (pos == scale));
        last_sel = (scale == 6'd0) && (pos == 6'd0);
      end
      ST_POINT: begin
        emit     = 1'b1;
        char_sel = CHAR_POINT;
      end
      ST_FRACTION: begin
        emit     = 1'b1;
        last_sel = (pos == 6'd0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    character <= char_sel;
    last      <= last_sel;
    case (state)
      ST_IDLE: begin
        if (start) begin
          // The magnitude is read as unsigned, so the most negative value needs no special case.
          neg     <= value_high[63];
          mag     <= value_high[63] ? (~value_in + 128'd1) : value_in;
          bcd     <= '0;
          bit_cnt <= 7'd0;
          scale   <= scale_in;
          int_on  <= (scale_in == 6'd0) || (total_digits > scale_in);
        end
      end
      ST_CONVERT: begin
        bcd     <= {bcd_adj[BCD_BITS-2:0], mag[MAG_BITS-1]};
        mag     <= {mag[MAG_BITS-2:0], 1'b0};
        bit_cnt <= bit_cnt + 7'd1;
      end
      ST_SIGN: begin
        pos  <= TOP_POS;
        seen <= 1'b0;
      end
      ST_INTEGER, ST_FRACTION: begin
        bcd  <= {bcd[BCD_BITS-5:0], 4'd0};
        pos  <= pos - 6'd1;
        seen <= seen | top_nz;
      end
      default: begin
        seen <= seen;
      end
    endcase
  end

endmodule

[design/sda_checker.sv]
// Port-level checker for the scaled decimal to ASCII formatter, with its bind.
// Depends on sda_pkg and on the ports of scaled_decimal_to_ascii.
module sda_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic last
);
  import sda_pkg::*;

  // A character only follows a cycle in which a value was being worked on.
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("character beat without a value in progress");

  // An accepted value keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted start");

  // The conversion phase emits nothing right after a start.
  a_quiet_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !strobe)
    else $error("character beat right after a start");

  // The last beat of a value is never followed at once by another.
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("character beat directly after the last one");

  // More characters are still to come, so the block must still be busy.
  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("block went idle before the last character");

endmodule

bind scaled_decimal_to_ascii sda_checker u_sda_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .last   (last)
);

[tb/testbench.sv]
// Self-checking testbench for the scaled decimal to ASCII formatter.
// Depends on sda_pkg for the character codes, register indexes and configuration width.
`timescale 1ns / 1ps

module testbench;
  import sda_pkg::*;

  // Generous bound on the run. The slowest correct run is roughly 220 values
  // plus the drains between phases, well within this bound.
  localparam int CYCLE_LIMIT = 600000;
  // Cycles to let pass after the last character before a register write or the end.
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 17;
  localparam int MAX_REPORTS = 30;

  // One character of the expected text.
  typedef struct {
    logic [7:0] code;
    logic       is_last;
  } char_beat_t;

  // One directed row: the configuration it runs under, the value and, where it
  // can be written down at a glance, the text it must produce.
  typedef struct {
    logic [5:0]  tot;
    logic [5:0]  frac;
    logic [127:0] value;
    string       text;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic signed [63:0]  value_high = '0;
  logic        [63:0]  value_low = '0;
  logic                cfg_write = 1'b0;
  logic                cfg_index = REG_TOTAL_DIGITS;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic                strobe;
  logic [7:0]          character;
  logic                last;

  // Expected characters, oldest first, across all values in flight.
  char_beat_t text_q[$];
  stim_row_t  rows[$];

  // Our copy of the two configuration registers.
  logic [5:0] cur_tot;
  logic [5:0] cur_frac;

  int fail_count = 0;
  int cycle_count = 0;

  scaled_decimal_to_ascii i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value_high (value_high),
    .value_low  (value_low),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .strobe     (strobe),
    .character  (character),
    .last       (last)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung block or a lost character ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Appends the text of the 128-bit value hi:lo, as formatted under the
  // current configuration, to the store of expected characters.
  function automatic void format_expected(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] mag;
    logic [3:0]   dig[NUM_DIGITS];
    logic         neg;
    int           sig;
    int           scale;
    char_beat_t   beats[$];
    char_beat_t   b;
    mag = {hi, lo};
    neg = hi[63];
    // Two's complement negation on 128 bits also gives the magnitude of the
    // most negative value correctly.
    if (neg) begin
      mag = -mag;
    end
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig[i] = 4'(mag % 128'd10);
      mag = mag / 128'd10;
    end
    // Number of significant digits, at least one so zero prints as "0".
    sig = 1;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (dig[i] != 4'd0) begin
        sig = i + 1;
      end
    end
    // A scale above the largest meaningful one is clamped.
    scale = (int'(cur_frac) > 38) ? 38 : int'(cur_frac);
    b.is_last = 1'b0;
    if (neg) begin
      b.code = CHAR_MINUS;
      beats.push_back(b);
    end
    if (scale == 0) begin
      for (int i = sig - 1; i >= 0; i--) begin
        b.code = CHAR_ZERO + 8'(dig[i]);
        beats.push_back(b);
      end
    end else begin
      // The integer part is dropped entirely when the precision leaves no
      // room for it, and printed in full, however wide, otherwise.
      if (int'(cur_tot) > scale) begin
        if (sig > scale) begin
          for (int i = sig - 1; i >= scale; i--) begin
            b.code = CHAR_ZERO + 8'(dig[i]);
            beats.push_back(b);
          end
        end else begin
          b.code = CHAR_ZERO;
          beats.push_back(b);
        end
      end
      b.code = CHAR_POINT;
      beats.push_back(b);
      for (int i = scale - 1; i >= 0; i--) begin
        b.code = CHAR_ZERO + 8'(dig[i]);
        beats.push_back(b);
      end
    end
    beats[beats.size() - 1].is_last = 1'b1;
    foreach (beats[i]) begin
      text_q.push_back(beats[i]);
    end
  endfunction

  // Appends a text typed in by hand to the store of expected characters.
  function automatic void expect_text(input string s);
    char_beat_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.code = s[i];
      b.is_last = (i == s.len() - 1);
      text_q.push_back(b);
    end
  endfunction

  function automatic logic [127:0] pow10(input int k);
    logic [127:0] p;
    p = 128'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 128'd10;
    end
    return p;
  endfunction

  function automatic logic [127:0] rand_word128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Random value, weighted toward the interesting places: powers of ten near
  // every scale boundary, small magnitudes of either sign, and the extremes.
  function automatic logic [127:0] rand_value();
    logic [127:0] v;
    case ($urandom_range(0, 5))
      0: v = rand_word128();
      1: begin
        v = pow10($urandom_range(0, 38)) - 128'd1 + 128'($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      2: begin
        v = 128'($urandom >> $urandom_range(0, 31));
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      3: begin
        v = rand_word128() >> $urandom_range(1, 127);
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      4: begin
        case ($urandom_range(0, 4))
          0: v = {1'b0, {127{1'b1}}};
          1: v = {1'b1, 127'b0};
          2: v = '0;
          3: v = '1;
          default: v = {64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
        endcase
      end
      default: v = rand_word128() >> $urandom_range(64, 127);
    endcase
    return v;
  endfunction

  function automatic void add_row(input logic [5:0] t, input logic [5:0] f,
                                  input logic [127:0] v, input string s);
    stim_row_t r;
    r.tot = t;
    r.frac = f;
    r.value = v;
    r.text = s;
    rows.push_back(r);
  endfunction

  // Offers one value after a gap of the given length and returns at the edge
  // where the beat was taken. start is left high, so that a following value
  // with no gap goes out back to back without start dropping in between.
  task automatic send_value(input logic [127:0] v, input int gap, input string text);
    if (gap > 0) begin
      // While idle the value ports carry noise the block must ignore.
      start <= 1'b0;
      value_high <= $signed({$urandom, $urandom});
      value_low <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value_high <= $signed(v[127:64]);
    value_low <= v[63:0];
    do begin
      @(posedge clk);
    end while (busy);
    if (text.len() > 0) begin
      expect_text(text);
    end else begin
      format_expected(v[127:64], v[63:0]);
    end
  endtask

  // Lets every expected character arrive and the block fall idle.
  task automatic drain();
    start <= 1'b0;
    while (text_q.size() != 0 || busy) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One write beat, followed by a cycle with the write enable low.
  task automatic write_reg(input logic idx, input logic [5:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_TOTAL_DIGITS) begin
      cur_tot = data;
    end else begin
      cur_frac = data;
    end
    @(posedge clk);
  endtask

  // Changes the configuration, only ever from an idle block.
  task automatic apply_config(input logic [5:0] t, input logic [5:0] f);
    if (t != cur_tot || f != cur_frac) begin
      drain();
      if (t != cur_tot) begin
        write_reg(REG_TOTAL_DIGITS, t);
      end
      if (f != cur_frac) begin
        write_reg(REG_FRACTION_DIGITS, f);
      end
    end
  endtask

  function automatic logic [5:0] pick_total();
    case ($urandom_range(0, 6))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd38;
      3: return 6'd39;
      4: return 6'd63;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [5:0] pick_fraction();
    case ($urandom_range(0, 7))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd37;
      3: return 6'd38;
      4: return 6'($urandom_range(39, 63));
      5: return 6'd63;
      default: return 6'($urandom_range(0, 38));
    endcase
  endfunction

  // Each character beat is checked against the oldest expectation. Beats are
  // sampled at the rising edge, so values are the ones held through the cycle.
  always @(posedge clk) begin
    char_beat_t exp_beat;
    if (!rst && strobe) begin
      if (text_q.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < MAX_REPORTS) begin
          $display("%0t: unexpected character beat: expected none, actual %h last %b",
                   $time, character, last);
        end
      end else begin
        exp_beat = text_q.pop_front();
        if (character !== exp_beat.code || last !== exp_beat.is_last) begin
          fail_count <= fail_count + 1;
          if (fail_count < MAX_REPORTS) begin
            if (character !== exp_beat.code) begin
              $display("%0t: character mismatch: expected %h actual %h",
                       $time, exp_beat.code, character);
            end
            if (last !== exp_beat.is_last) begin
              $display("%0t: last mismatch: expected %b actual %b",
                       $time, exp_beat.is_last, last);
            end
          end
        end
      end
    end
  end

  initial begin
    logic [127:0] v_min;
    logic [127:0] v_max;
    logic [5:0]   t;
    logic [5:0]   f;
    int           gap;
    cur_tot = 6'd38;
    cur_frac = 6'd0;
    v_max = {1'b0, {127{1'b1}}};
    v_min = {1'b1, 127'b0};

    // Directed rows. The first ones run under the values left by reset.
    add_row(6'd38, 6'd0, 128'd0, "0");
    add_row(6'd38, 6'd0, 128'd1, "1");
    add_row(6'd38, 6'd0, {128{1'b1}}, "-1");
    add_row(6'd38, 6'd0, v_max, "170141183460469231731687303715884105727");
    add_row(6'd38, 6'd0, v_min, "-170141183460469231731687303715884105728");
    add_row(6'd0, 6'd0, 128'd42, "42");
    add_row(6'd38, 6'd2, 128'd12345, "123.45");
    add_row(6'd38, 6'd2, -128'd5, "-0.05");
    add_row(6'd38, 6'd2, 128'd0, "0.00");
    add_row(6'd2, 6'd2, 128'd12345, ".45");
    add_row(6'd1, 6'd3, -128'd7, "-.007");
    add_row(6'd38, 6'd1, -128'd10, "-1.0");
    add_row(6'd3, 6'd1, 128'd99999, "9999.9");
    add_row(6'd38, 6'd38, 128'd0, "");
    add_row(6'd38, 6'd38, v_min, "");
    add_row(6'd39, 6'd38, v_max, "");
    add_row(6'd5, 6'd63, 128'd1, "");

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      apply_config(rows[i].tot, rows[i].frac);
      gap = int'($urandom_range(0, 13));
      send_value(rows[i].value, gap, rows[i].text);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      t = pick_total();
      f = pick_fraction();
      apply_config(t, f);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        gap = int'($urandom_range(0, 13));
        send_value(rand_value(), gap, "");
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
